FILE: hw/rtl/pre_pkg.sv
// ----------------------------------------------------------------------------
// Polynomial range evaluator package
// Field widths, status codes and fixed-point limits shared by the channel
// interfaces and the evaluator.
// ----------------------------------------------------------------------------
package pre_pkg;

  localparam int COEF_W = 27;
  localparam int X_W    = 27;
  localparam int STEP_W = 28;
  localparam int IDX_W  = 7;
  localparam int DEG_W  = 7;
  localparam int ACC_W  = 64;
  localparam int ST_W   = 3;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [ST_W-1:0] {
    ST_OK      = 3'd0,
    ST_SAT     = 3'd1,
    ST_TRUNC   = 3'd2,
    ST_BADSTEP = 3'd3,
    ST_EMPTY   = 3'd4
  } status_t;

  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_SWEEP = 1'b1;

endpackage

FILE: hw/rtl/pre_req_if.sv
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying coefficient loads and sweep requests.
// ----------------------------------------------------------------------------
interface pre_req_if import pre_pkg::*; ();

  logic                     valid;
  logic                     ready;
  logic                     req_type;
  logic [IDX_W-1:0]         coef_index;
  logic signed [COEF_W-1:0] coef_value;
  logic signed [X_W-1:0]    sweep_start;
  logic signed [X_W-1:0]    sweep_end;
  logic signed [STEP_W-1:0] sweep_step;

  modport source (
    output valid, req_type, coef_index, coef_value, sweep_start, sweep_end, sweep_step,
    input  ready
  );

  modport sink (
    input  valid, req_type, coef_index, coef_value, sweep_start, sweep_end, sweep_step,
    output ready
  );

endinterface

FILE: hw/rtl/pre_res_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one evaluated point per transaction.
// ----------------------------------------------------------------------------
interface pre_res_if import pre_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic signed [X_W-1:0]   x_point;
  logic signed [ACC_W-1:0] poly_value;
  logic [ST_W-1:0]         status;
  logic                    last;

  modport source (
    output valid, x_point, poly_value, status, last,
    input  ready
  );

  modport sink (
    input  valid, x_point, poly_value, status, last,
    output ready
  );

endinterface

FILE: hw/rtl/pre_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pre_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/polynomial_range_evaluator.sv
// ----------------------------------------------------------------------------
// Polynomial range evaluator
// Evaluates a stored polynomial by Horner's rule in fixed point over a range
// of x values, one result transaction per point.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Contents
//   req      in         coefficient load or sweep (start, end, step)
//   res      out        x_point, poly_value, status, last
//   cfg      in         poly_degree write (cfg_wen, cfg_wdata)
//
// A load is written to the coefficient RAM when accepted. Each point takes
// d+1 Horner steps and an emit step, d being the effective degree; each
// Horner step uses one shared 32x27 multiplier (magnitude, low product,
// high product, round, add). A bad step or empty range gives a single result.
// Reset clears control state only; coefficients are undefined until loaded.
// The evaluator stalls only when a result is ready and the output register
// still holds an untaken transaction.
// ----------------------------------------------------------------------------
module polynomial_range_evaluator import pre_pkg::*; #(
  parameter int MAX_DEGREE = 127,
  parameter int MAX_POINTS = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wen,
  input  logic [DEG_W-1:0] cfg_wdata,
  pre_req_if.sink          req,
  pre_res_if.source        res
);

  localparam int AW = $clog2(MAX_DEGREE + 1);
  localparam int CW = $clog2(MAX_POINTS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_MAG, S_MUL_LO, S_MUL_HI, S_RND, S_ADD, S_EMIT
  } state_t;

  state_t                   state;
  logic [DEG_W-1:0]         poly_degree;
  logic signed [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]         mag;
  logic                     neg;
  logic signed [X_W-1:0]    x;
  logic signed [X_W-1:0]    x_end;
  logic signed [STEP_W-1:0] step;
  logic [AW-1:0]            idx;
  logic [CW-1:0]            cnt;
  logic                     sat;
  logic [58:0]              p0;
  logic [58:0]              p1;
  logic signed [ACC_W-1:0]  prod;
  logic signed [X_W-1:0]    res_x;
  logic signed [ACC_W-1:0]  res_val;
  status_t                  res_st;
  logic                     res_last;
  logic                     out_valid;
  logic signed [X_W-1:0]    out_x;
  logic signed [ACC_W-1:0]  out_val;
  status_t                  out_st;
  logic                     out_last;

  logic [AW-1:0]            deg_eff;
  logic                     load_we;
  logic [COEF_W-1:0]        coef;
  logic [X_W-1:0]           xu;
  logic [X_W-1:0]           mx;
  logic [31:0]              mul_a;
  logic [58:0]              mul_p;
  logic [91:0]              rnd;
  logic [75:0]              q;
  logic                     q_big;
  logic                     rnd_sat;
  logic signed [ACC_W-1:0]  rnd_val;
  logic signed [ACC_W:0]    sum;
  logic                     add_sat;
  logic signed [ACC_W-1:0]  add_val;
  logic signed [X_W+1:0]    nx;
  logic                     more;
  logic                     cap;
  logic                     out_free;

  assign deg_eff = ({25'b0, poly_degree} > 32'(MAX_DEGREE)) ? AW'(MAX_DEGREE)
                                                             : AW'(poly_degree);
  assign req.ready = (state == S_IDLE);
  assign load_we = req.valid && req.ready && (req.req_type == REQ_LOAD) &&
                   ({25'b0, req.coef_index} <= 32'(MAX_DEGREE));

  pre_ram #(
    .WIDTH(COEF_W),
    .DEPTH(MAX_DEGREE + 1)
  ) u_coef_ram (
    .clk  (clk),
    .we   (load_we),
    .waddr(AW'(req.coef_index)),
    .wdata(req.coef_value),
    .raddr(idx),
    .rdata(coef)
  );

  assign xu    = x;
  assign mx    = xu[X_W-1] ? (~xu + X_W'(1)) : xu;
  assign mul_a = (state == S_MUL_LO) ? mag[31:0] : mag[63:32];
  assign mul_p = 59'(mul_a) * 59'(mx);

  assign rnd   = 92'({p1, 32'b0}) + 92'(p0) + 92'(16'h8000);
  assign q     = rnd[91:16];
  assign q_big = |q[75:64];

  always_comb begin
    if (neg) begin
      rnd_sat = q_big || (q[63] && (|q[62:0]));
      rnd_val = rnd_sat ? ACC_MIN : ACC_W'(64'd0 - q[63:0]);
    end else begin
      rnd_sat = q_big || q[63];
      rnd_val = rnd_sat ? ACC_MAX : $signed(q[63:0]);
    end
  end

  assign sum     = {prod[ACC_W-1], prod} + (ACC_W+1)'($signed(coef));
  assign add_sat = (sum[ACC_W] != sum[ACC_W-1]);
  assign add_val = add_sat ? (sum[ACC_W] ? ACC_MIN : ACC_MAX) : sum[ACC_W-1:0];

  assign nx   = {{2{x[X_W-1]}}, x} + {step[STEP_W-1], step};
  assign more = (nx <= $signed({{2{x_end[X_W-1]}}, x_end}));
  assign cap  = ((cnt + CW'(1)) == CW'(MAX_POINTS));

  assign out_free = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      poly_degree <= '0;
      out_valid   <= 1'b0;
      acc         <= '0;
      x           <= '0;
      cnt         <= '0;
      sat         <= 1'b0;
    end else begin
      if (cfg_wen) begin
        poly_degree <= cfg_wdata;
      end
      if (state == S_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid && req.req_type == REQ_SWEEP) begin
            x     <= req.sweep_start;
            x_end <= req.sweep_end;
            step  <= req.sweep_step;
            if (req.sweep_step[STEP_W-1] || (req.sweep_step == '0)) begin
              res_x    <= req.sweep_start;
              res_val  <= '0;
              res_st   <= ST_BADSTEP;
              res_last <= 1'b1;
              state    <= S_EMIT;
            end else if (req.sweep_start > req.sweep_end) begin
              res_x    <= req.sweep_start;
              res_val  <= '0;
              res_st   <= ST_EMPTY;
              res_last <= 1'b1;
              state    <= S_EMIT;
            end else begin
              acc   <= '0;
              sat   <= 1'b0;
              cnt   <= '0;
              idx   <= deg_eff;
              state <= S_MAG;
            end
          end
        end
        S_MAG: begin
          neg   <= acc[ACC_W-1] ^ x[X_W-1];
          mag   <= acc[ACC_W-1] ? (64'd0 - acc) : acc;
          state <= S_MUL_LO;
        end
        S_MUL_LO: begin
          p0    <= mul_p;
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          p1    <= mul_p;
          state <= S_RND;
        end
        S_RND: begin
          prod  <= rnd_val;
          sat   <= sat | rnd_sat;
          state <= S_ADD;
        end
        S_ADD: begin
          acc <= add_val;
          if (idx == '0) begin
            res_x    <= x;
            res_val  <= add_val;
            res_last <= cap || !more;
            if (cap && more) begin
              res_st <= ST_TRUNC;
            end else if (sat || add_sat) begin
              res_st <= ST_SAT;
            end else begin
              res_st <= ST_OK;
            end
            state <= S_EMIT;
          end else begin
            sat   <= sat | add_sat;
            idx   <= idx - AW'(1);
            state <= S_MAG;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_x     <= res_x;
            out_val   <= res_val;
            out_st    <= res_st;
            out_last  <= res_last;
            if (res_last) begin
              state <= S_IDLE;
            end else begin
              x     <= nx[X_W-1:0];
              cnt   <= cnt + CW'(1);
              acc   <= '0;
              sat   <= 1'b0;
              idx   <= deg_eff;
              state <= S_MAG;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res.valid      = out_valid;
  assign res.x_point    = out_x;
  assign res.poly_value = out_val;
  assign res.status     = out_st;
  assign res.last       = out_last;

`ifndef SYNTH
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD) |-> (idx <= deg_eff))
    else $error("Horner index exceeds the effective degree.");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    (cnt <= CW'(MAX_POINTS)))
    else $error("Point count exceeds the sweep limit.");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.ready && (res.status == ST_BADSTEP || res.status == ST_EMPTY))
    |-> (res.last && res.poly_value == '0))
    else $error("Rejected sweep result is not a final zero transaction.");

  a_emit_from_add: assert property (@(posedge clk) disable iff (rst)
    ($rose(state == S_EMIT) && $past(state) == S_ADD) |-> ($past(idx) == '0))
    else $error("Point emitted before the last Horner step.");
`endif

endmodule

FILE: test/tb_polynomial_range_evaluator.sv
// ----------------------------------------------------------------------------
// Polynomial range evaluator testbench
// A directed table covers the coefficient and range extremes, bad steps, empty
// ranges, saturation and truncation. Random phases at several degrees follow.
// Results are checked against an in-bench Horner predictor or the expected
// value of a directed row; both channels idle at random but in the last phase.
// ----------------------------------------------------------------------------
module tb_polynomial_range_evaluator import pre_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint Q_ONE       = 65536;
  localparam longint Q_MAX       = 1000 * Q_ONE;
  localparam longint Q_MIN       = -Q_MAX;
  localparam longint STEP_MAX    = 2 * Q_MAX;
  localparam int     POINT_LIMIT = 64;
  localparam int     COEF_DEPTH  = 128;
  localparam int     WIDE_DEGREE = 31;

  typedef enum {ROW_LOAD, ROW_SWEEP, ROW_DEGREE} row_kind_t;

  typedef struct {
    logic                     kind;
    logic [IDX_W-1:0]         index;
    logic signed [COEF_W-1:0] coef;
    logic signed [X_W-1:0]    x_first;
    logic signed [X_W-1:0]    x_stop;
    logic signed [STEP_W-1:0] x_step;
  } request_t;

  typedef struct {
    logic signed [X_W-1:0]   x;
    logic signed [ACC_W-1:0] value;
    status_t                 st;
    logic                    last;
  } point_t;

  typedef struct {
    row_kind_t kind;
    int        idx;
    longint    a;
    longint    b;
    longint    c;
    bit        typed;
    longint    tval;
    status_t   tst;
  } row_t;

  logic clk;
  logic rst;
  logic cfg_wen;
  logic [DEG_W-1:0] cfg_wdata;

  pre_req_if req_ch ();
  pre_res_if res_ch ();

  polynomial_range_evaluator i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .res       (res_ch)
  );

  logic signed [COEF_W-1:0] coef_mem [COEF_DEPTH];
  logic [DEG_W-1:0]         degree_now = '0;
  point_t                   expected_points [$];

  bit idle_en = 1'b1;
  int res_stall = 0;
  int mismatches = 0;
  int loads_sent = 0;
  int sweeps_sent = 0;
  int degree_writes = 0;
  int points_seen = 0;
  int sat_seen = 0;
  int trunc_seen = 0;
  int badstep_seen = 0;
  int empty_seen = 0;

  row_t directed_rows [20] = '{
    '{ROW_LOAD,   0,   Q_MAX,  0,     0,         1'b0, 0,     ST_OK},
    '{ROW_SWEEP,  0,   0,      0,     1,         1'b1, Q_MAX, ST_OK},
    '{ROW_SWEEP,  0,   Q_MIN,  Q_MAX, 0,         1'b1, 0,     ST_BADSTEP},
    '{ROW_SWEEP,  0,   Q_MAX,  Q_MIN, -STEP_MAX, 1'b1, 0,     ST_BADSTEP},
    '{ROW_SWEEP,  0,   Q_MAX,  Q_MIN, STEP_MAX,  1'b1, 0,     ST_EMPTY},
    '{ROW_SWEEP,  0,   1,      0,     1,         1'b1, 0,     ST_EMPTY},
    '{ROW_LOAD,   0,   Q_MIN,  0,     0,         1'b0, 0,     ST_OK},
    '{ROW_SWEEP,  0,   Q_MIN,  Q_MAX, 1,         1'b0, 0,     ST_OK},
    '{ROW_SWEEP,  0,   Q_MIN,  Q_MAX, STEP_MAX,  1'b0, 0,     ST_OK},
    '{ROW_SWEEP,  0,   Q_MAX,  Q_MAX, STEP_MAX,  1'b1, Q_MIN, ST_OK},
    '{ROW_LOAD,   1,   Q_MAX,  0,     0,         1'b0, 0,     ST_OK},
    '{ROW_LOAD,   2,   Q_MAX,  0,     0,         1'b0, 0,     ST_OK},
    '{ROW_LOAD,   3,   Q_MAX,  0,     0,         1'b0, 0,     ST_OK},
    '{ROW_LOAD,   4,   Q_MAX,  0,     0,         1'b0, 0,     ST_OK},
    '{ROW_LOAD,   127, Q_MIN,  0,     0,         1'b0, 0,     ST_OK},
    '{ROW_DEGREE, 4,   0,      0,     0,         1'b0, 0,     ST_OK},
    '{ROW_SWEEP,  0,   Q_MAX,  Q_MAX, 1,         1'b0, 0,     ST_OK},
    '{ROW_SWEEP,  0,   Q_MIN,  Q_MIN, 1,         1'b0, 0,     ST_OK},
    '{ROW_SWEEP,  0,   -Q_ONE, Q_ONE, Q_ONE / 2, 1'b0, 0,     ST_OK},
    '{ROW_SWEEP,  0,   Q_MIN,  Q_MAX, 2048000,   1'b0, 0,     ST_OK}
  };

  always #2 clk = ~clk;

  function automatic longint pick(input longint top);
    return longint'($urandom_range(32'(top)));
  endfunction

  function automatic longint rand_span(input longint span);
    return -span + pick(2 * span);
  endfunction

  function automatic logic signed [ACC_W-1:0] round_mul(input logic signed [ACC_W-1:0] a,
                                                        input longint xv, inout bit sat);
    logic signed [95:0] aw, xw, prod;
    logic [95:0] mag, q;
    aw = 96'(a);
    xw = 96'(xv);
    prod = aw * xw;
    if (prod < 0) mag = -prod;
    else mag = prod;
    q = (mag + 96'd32768) >> 16;
    if (prod < 0) begin
      if (q > 96'h8000_0000_0000_0000) begin
        sat = 1'b1;
        return ACC_MIN;
      end
      return -q[ACC_W-1:0];
    end
    if (q >= 96'h8000_0000_0000_0000) begin
      sat = 1'b1;
      return ACC_MAX;
    end
    return q[ACC_W-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] p,
                                                      input logic signed [COEF_W-1:0] c,
                                                      inout bit sat);
    logic signed [ACC_W:0] s;
    s = (ACC_W+1)'(p) + (ACC_W+1)'(c);
    if (s > ACC_MAX) begin
      sat = 1'b1;
      return ACC_MAX;
    end
    if (s < ACC_MIN) begin
      sat = 1'b1;
      return ACC_MIN;
    end
    return s[ACC_W-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] horner_at(input longint xv, output bit sat);
    logic signed [ACC_W-1:0] acc, prod;
    sat = 1'b0;
    acc = '0;
    for (int i = int'(degree_now); i >= 0; i--) begin
      prod = round_mul(acc, xv, sat);
      acc = sat_add(prod, coef_mem[i], sat);
    end
    return acc;
  endfunction

  task automatic predict_sweep(input longint first, input longint stop, input longint step);
    point_t pts [$];
    point_t pt;
    longint xv;
    bit sat;
    if (step <= 0) begin
      pts.push_back('{X_W'(first), '0, ST_BADSTEP, 1'b1});
    end else if (first > stop) begin
      pts.push_back('{X_W'(first), '0, ST_EMPTY, 1'b1});
    end else begin
      xv = first;
      while (pts.size() < POINT_LIMIT && xv <= stop) begin
        pt.value = horner_at(xv, sat);
        pt.x = X_W'(xv);
        pt.st = sat ? ST_SAT : ST_OK;
        pt.last = 1'b0;
        pts.push_back(pt);
        xv += step;
      end
      if (xv <= stop) pts[pts.size() - 1].st = ST_TRUNC;
      pts[pts.size() - 1].last = 1'b1;
    end
    foreach (pts[i]) expected_points.push_back(pts[i]);
  endtask

  function automatic request_t random_request();
    request_t rq;
    rq.kind = 1'($urandom_range(1));
    rq.index = IDX_W'($urandom_range(COEF_DEPTH - 1));
    rq.coef = COEF_W'(rand_span(Q_MAX));
    rq.x_first = X_W'(rand_span(Q_MAX));
    rq.x_stop = X_W'(rand_span(Q_MAX));
    rq.x_step = STEP_W'(rand_span(STEP_MAX));
    return rq;
  endfunction

  function automatic request_t make_sweep();
    request_t rq;
    longint lo, hi, first, stop, step;
    int npts;
    int unsigned mode;
    rq = random_request();
    rq.kind = REQ_SWEEP;
    mode = $urandom_range(3);
    if (mode == 0) begin
      lo = Q_MIN;
      hi = Q_MAX;
    end else if (mode == 1) begin
      lo = -2 * Q_ONE;
      hi = 2 * Q_ONE;
    end else begin
      lo = -Q_ONE;
      hi = Q_ONE;
    end
    npts = (degree_now > 31) ? $urandom_range(1, 6) : $urandom_range(1, 70);
    first = lo + pick(hi - lo);
    step = (hi - first) / npts;
    if (step < 1) step = 1;
    step = 1 + pick(step - 1);
    stop = first + (npts - 1) * step + pick(step - 1);
    if (stop > Q_MAX) stop = Q_MAX;
    rq.x_first = X_W'(first);
    rq.x_stop = X_W'(stop);
    rq.x_step = STEP_W'(step);
    return rq;
  endfunction

  function automatic request_t make_noise();
    request_t rq;
    longint first;
    rq = random_request();
    rq.kind = REQ_SWEEP;
    if ($urandom_range(1)) begin
      rq.x_step = STEP_W'(-pick(STEP_MAX));
    end else begin
      first = Q_MIN + 1 + pick(2 * Q_MAX - 1);
      rq.x_first = X_W'(first);
      rq.x_stop = X_W'(Q_MIN + pick(first - Q_MIN - 1));
      rq.x_step = STEP_W'(1 + pick(STEP_MAX - 1));
    end
    return rq;
  endfunction

  task automatic issue(input request_t rq, input bit typed, input point_t typed_pt);
    if (idle_en && $urandom_range(3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.req_type <= rq.kind;
    req_ch.coef_index <= rq.index;
    req_ch.coef_value <= rq.coef;
    req_ch.sweep_start <= rq.x_first;
    req_ch.sweep_end <= rq.x_stop;
    req_ch.sweep_step <= rq.x_step;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (rq.kind == REQ_LOAD) begin
      coef_mem[rq.index] = rq.coef;
      loads_sent++;
    end else begin
      sweeps_sent++;
      if (typed) expected_points.push_back(typed_pt);
      else predict_sweep(longint'(rq.x_first), longint'(rq.x_stop), longint'(rq.x_step));
    end
  endtask

  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_degree(input int d);
    wait_idle();
    cfg_wen <= 1'b1;
    cfg_wdata <= DEG_W'(d);
    @(posedge clk);
    cfg_wen <= 1'b0;
    degree_now = DEG_W'(d);
    degree_writes++;
  endtask

  task automatic check_point();
    point_t want;
    if (expected_points.size() == 0) begin
      if (mismatches < 10)
        $display("%0t: unexpected result x=%0d value=%0d status=%0d last=%0b", $time,
                 res_ch.x_point, res_ch.poly_value, res_ch.status, res_ch.last);
      mismatches++;
    end else begin
      want = expected_points.pop_front();
      if (res_ch.x_point !== want.x || res_ch.poly_value !== want.value ||
          res_ch.status !== want.st || res_ch.last !== want.last) begin
        if (mismatches < 10)
          $display("%0t: mismatch exp x=%0d value=%0d status=%0d last=%0b, ",
                   $time, want.x, want.value, want.st, want.last,
                   "got x=%0d value=%0d status=%0d last=%0b", res_ch.x_point,
                   res_ch.poly_value, res_ch.status, res_ch.last);
        mismatches++;
      end
    end
    points_seen++;
    if (res_ch.status == ST_SAT) sat_seen++;
    if (res_ch.status == ST_TRUNC) trunc_seen++;
    if (res_ch.status == ST_BADSTEP) badstep_seen++;
    if (res_ch.status == ST_EMPTY) empty_seen++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) check_point();
      if (res_stall != 0) res_stall--;
      else if (idle_en && $urandom_range(4) == 0) res_stall = $urandom_range(1, 3);
      res_ch.ready <= (res_stall == 0);
    end
  end

  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    request_t rq;
    point_t tpt;
    int phase_deg [6];
    clk = 1'b0;
    rst <= 1'b1;
    cfg_wen <= 1'b0;
    cfg_wdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.req_type <= REQ_LOAD;
    req_ch.coef_index <= '0;
    req_ch.coef_value <= '0;
    req_ch.sweep_start <= '0;
    req_ch.sweep_end <= '0;
    req_ch.sweep_step <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_DEGREE) begin
        set_degree(directed_rows[i].idx);
      end else begin
        rq = random_request();
        if (directed_rows[i].kind == ROW_LOAD) begin
          rq.kind = REQ_LOAD;
          rq.index = IDX_W'(directed_rows[i].idx);
          rq.coef = COEF_W'(directed_rows[i].a);
        end else begin
          rq.kind = REQ_SWEEP;
          rq.x_first = X_W'(directed_rows[i].a);
          rq.x_stop = X_W'(directed_rows[i].b);
          rq.x_step = STEP_W'(directed_rows[i].c);
        end
        tpt.x = X_W'(directed_rows[i].a);
        tpt.value = ACC_W'(directed_rows[i].tval);
        tpt.st = directed_rows[i].tst;
        tpt.last = 1'b1;
        issue(rq, directed_rows[i].typed, tpt);
      end
    end

    phase_deg = '{2, WIDE_DEGREE, 0, $urandom_range(3, 15), 1, $urandom_range(3, 15)};
    tpt = '{'0, '0, ST_OK, 1'b0};
    foreach (phase_deg[p]) begin
      if (phase_deg[p] == WIDE_DEGREE) begin
        for (int i = 0; i <= WIDE_DEGREE; i++) begin
          rq = random_request();
          rq.kind = REQ_LOAD;
          rq.index = IDX_W'(i);
          if ($urandom_range(3) != 0) rq.coef = COEF_W'(rand_span(Q_ONE));
          issue(rq, 1'b0, tpt);
        end
      end
      idle_en = (p != 5);
      set_degree(phase_deg[p]);
      for (int k = 0; k < 8; k++) begin
        if (p == 2 && k == 4) wait_idle();
        case ($urandom_range(9))
          0, 1, 2: begin
            rq = random_request();
            rq.kind = REQ_LOAD;
            if ($urandom_range(1)) rq.coef = COEF_W'(rand_span(Q_ONE));
          end
          3: rq = make_noise();
          default: rq = make_sweep();
        endcase
        issue(rq, 1'b0, tpt);
      end
    end

    wait_idle();
    repeat (700) @(posedge clk);
    $display("Run covered %0d coefficient loads and %0d sweeps over %0d degree settings.",
             loads_sent, sweeps_sent, degree_writes);
    $display("%0d points checked: %0d saturated, %0d truncated, ",
             points_seen, sat_seen, trunc_seen,
             "%0d bad step, %0d empty, %0d mismatches.",
             badstep_seen, empty_seen, mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
